// ===== rtl/jdzd_pkg.sv =====
// Shared constants, types and axis arithmetic for the joystick dead-zone direction block.
package jdzd_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_SHIFT   = 16;
  localparam int PERCENT_BITS = 7;
  localparam int DIR_BITS     = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = (GAIN_BITS > SAMPLE_BITS) ? GAIN_BITS : SAMPLE_BITS;

  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int PCT_BITS  = PROD_BITS - GAIN_SHIFT;
  localparam int CMP_BITS  = (PCT_BITS > PERCENT_BITS) ? PCT_BITS : PERCENT_BITS;

  localparam int IN_DATA_BITS  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = DIR_BITS + PERCENT_BITS + 1;
  localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [PERCENT_BITS-1:0] PERCENT_MAX = PERCENT_BITS'(100);

  typedef enum logic [DIR_BITS-1:0] {
    DIR_CENTER = 3'd0,
    DIR_UP     = 3'd1,
    DIR_DOWN   = 3'd2,
    DIR_LEFT   = 3'd3,
    DIR_RIGHT  = 3'd4
  } dir_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_REST      = 3'd0,
    CFG_Y_REST      = 3'd1,
    CFG_X_GAIN_ABV  = 3'd2,
    CFG_X_GAIN_BLW  = 3'd3,
    CFG_Y_GAIN_ABV  = 3'd4,
    CFG_Y_GAIN_BLW  = 3'd5,
    CFG_DEAD_ZONE   = 3'd6,
    CFG_ACT_MARGIN  = 3'd7
  } cfg_idx_t;

  localparam logic [SAMPLE_BITS-1:0]  RST_X_REST     = SAMPLE_BITS'(2265);
  localparam logic [SAMPLE_BITS-1:0]  RST_Y_REST     = SAMPLE_BITS'(2231);
  localparam logic [GAIN_BITS-1:0]    RST_X_GAIN_ABV = GAIN_BITS'(4369);
  localparam logic [GAIN_BITS-1:0]    RST_X_GAIN_BLW = GAIN_BITS'(3855);
  localparam logic [GAIN_BITS-1:0]    RST_Y_GAIN_ABV = GAIN_BITS'(3676);
  localparam logic [GAIN_BITS-1:0]    RST_Y_GAIN_BLW = GAIN_BITS'(4096);
  localparam logic [PERCENT_BITS-1:0] RST_DEAD_ZONE  = PERCENT_BITS'(5);
  localparam logic [PERCENT_BITS-1:0] RST_ACT_MARGIN = PERCENT_BITS'(50);

  typedef struct packed {
    logic [PERCENT_BITS-1:0] percent;
    dir_t                    dir;
  } axis_t;

  function automatic axis_t axis_eval(
    input logic [SAMPLE_BITS-1:0]  sample,
    input logic [SAMPLE_BITS-1:0]  rest,
    input logic [GAIN_BITS-1:0]    gain_above,
    input logic [GAIN_BITS-1:0]    gain_below,
    input logic [PERCENT_BITS-1:0] dead_zone,
    input dir_t                    below_dir,
    input dir_t                    above_dir
  );
    logic [SAMPLE_BITS-1:0] distance;
    logic [GAIN_BITS-1:0]   gain;
    logic [PROD_BITS-1:0]   prod;
    logic [CMP_BITS-1:0]    pct;
    axis_t                  res;
    distance = (sample > rest) ? (sample - rest) : (rest - sample);
    gain = (sample > rest) ? gain_above : gain_below;
    prod = PROD_BITS'(distance) * PROD_BITS'(gain);
    pct  = CMP_BITS'(prod[PROD_BITS-1:GAIN_SHIFT]);
    if (pct <= CMP_BITS'(dead_zone)) begin
      res.percent = '0;
      res.dir     = DIR_CENTER;
    end else if (pct > CMP_BITS'(PERCENT_MAX)) begin
      res.percent = PERCENT_MAX;
      res.dir     = (sample < rest) ? below_dir : above_dir;
    end else begin
      res.percent = PERCENT_BITS'(pct);
      res.dir     = (sample < rest) ? below_dir : above_dir;
    end
    return res;
  endfunction

endpackage

// ===== rtl/joystick_dead_zone_direction_top.sv =====
// Top level of the joystick dead-zone direction block.
// Each request is one X/Y sample pair with a mode flag and yields one result. A request is
// registered on entry, then combinational logic (one 12x16 multiply per axis, dead-zone
// compare, clamp, held-direction update) loads the result register. One request can enter
// every cycle unless m_tready stalls the output. Navigate mode reports the held navigate
// direction with y_percent and increment_up at 0; test mode reports the held X test
// direction, the Y percent and whether Y points up. Write configuration only while idle.
module joystick_dead_zone_direction_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // x_sample, y_sample
  input  logic [jdzd_pkg::IN_DATA_BITS-1:0]    s_tdata,
  // action
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // direction, y_percent, increment_up, zero fill
  output logic [jdzd_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  input  logic                                 cfg_we,
  input  logic [jdzd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [jdzd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import jdzd_pkg::*;

  logic [SAMPLE_BITS-1:0]  x_rest_offset;
  logic [SAMPLE_BITS-1:0]  y_rest_offset;
  logic [GAIN_BITS-1:0]    x_gain_above;
  logic [GAIN_BITS-1:0]    x_gain_below;
  logic [GAIN_BITS-1:0]    y_gain_above;
  logic [GAIN_BITS-1:0]    y_gain_below;
  logic [PERCENT_BITS-1:0] dead_zone_percent;
  logic [PERCENT_BITS-1:0] act_threshold;

  logic                    in_valid;
  logic                    in_action;
  logic [SAMPLE_BITS-1:0]  in_x;
  logic [SAMPLE_BITS-1:0]  in_y;

  logic                    out_valid;
  dir_t                    out_direction;
  logic [PERCENT_BITS-1:0] out_y_percent;
  logic                    out_increment_up;

  dir_t                    held_direction;
  dir_t                    held_direction_next;
  dir_t                    held_test_direction;
  dir_t                    held_test_direction_next;

  axis_t                   x_axis;
  axis_t                   y_axis;
  logic                    advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_BITS'({out_increment_up, out_y_percent, out_direction});

  always_ff @(posedge clk) begin
    if (rst) begin
      x_rest_offset     <= RST_X_REST;
      y_rest_offset     <= RST_Y_REST;
      x_gain_above      <= RST_X_GAIN_ABV;
      x_gain_below      <= RST_X_GAIN_BLW;
      y_gain_above      <= RST_Y_GAIN_ABV;
      y_gain_below      <= RST_Y_GAIN_BLW;
      dead_zone_percent <= RST_DEAD_ZONE;
      act_threshold     <= RST_ACT_MARGIN;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_X_REST:     x_rest_offset     <= cfg_data[SAMPLE_BITS-1:0];
        CFG_Y_REST:     y_rest_offset     <= cfg_data[SAMPLE_BITS-1:0];
        CFG_X_GAIN_ABV: x_gain_above      <= cfg_data[GAIN_BITS-1:0];
        CFG_X_GAIN_BLW: x_gain_below      <= cfg_data[GAIN_BITS-1:0];
        CFG_Y_GAIN_ABV: y_gain_above      <= cfg_data[GAIN_BITS-1:0];
        CFG_Y_GAIN_BLW: y_gain_below      <= cfg_data[GAIN_BITS-1:0];
        CFG_DEAD_ZONE:  dead_zone_percent <= cfg_data[PERCENT_BITS-1:0];
        CFG_ACT_MARGIN: act_threshold     <= cfg_data[PERCENT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_x      <= s_tdata[SAMPLE_BITS-1:0];
      in_y      <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
  end

  always_comb begin
    x_axis = axis_eval(in_x, x_rest_offset, x_gain_above, x_gain_below,
                       dead_zone_percent, DIR_RIGHT, DIR_LEFT);
    y_axis = axis_eval(in_y, y_rest_offset, y_gain_above, y_gain_below,
                       dead_zone_percent, DIR_UP, DIR_DOWN);
  end

  always_comb begin
    held_direction_next      = held_direction;
    held_test_direction_next = held_test_direction;
    if (!in_action) begin
      if (x_axis.percent >= act_threshold || y_axis.percent >= act_threshold ||
          (x_axis.percent == '0 && y_axis.percent == '0)) begin
        held_direction_next = (x_axis.percent >= y_axis.percent) ? x_axis.dir : y_axis.dir;
      end
    end else begin
      if (x_axis.percent >= act_threshold || x_axis.percent == '0) begin
        held_test_direction_next = x_axis.dir;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_direction      <= DIR_CENTER;
      held_test_direction <= DIR_CENTER;
    end else if (advance) begin
      held_direction      <= held_direction_next;
      held_test_direction <= held_test_direction_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!in_action) begin
        out_direction    <= held_direction_next;
        out_y_percent    <= '0;
        out_increment_up <= 1'b0;
      end else begin
        out_direction    <= held_test_direction_next;
        out_y_percent    <= y_axis.percent;
        out_increment_up <= (y_axis.dir == DIR_UP);
      end
    end
  end

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(held_direction) && $stable(held_test_direction))
    else $error("held direction changed without a request");

  a_up_not_centered: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_increment_up |-> out_y_percent != '0)
    else $error("increment_up set with zero Y percent");

  a_percent_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_y_percent <= PERCENT_MAX)
    else $error("Y percent above clamp");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> !s_tready)
    else $error("input taken while input register is held");

endmodule
